// ===== rtl/core/rfma_pkg.sv =====
// Package for the register free-map allocator.
// Holds the request and result word types and the op and status codes.
// No dependencies.
`timescale 1ns / 1ps

package rfma_pkg;

    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int SIZE_W = 7;

    // Request opcodes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_CAPACITY = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] reg_index;
        logic [CNT_W-1:0] block_count;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  granted_index;
        logic [1:0]        status;
        logic [SIZE_W-1:0] file_size;
    } rsp_t;

endpackage

// ===== rtl/core/register_free_map_allocator.sv =====
// Top level of the register free-map allocator: request register, decision
// logic, result register and allocator state. Depends on rfma_pkg, rfma_decide.
//
//   Channel | Ports                        | Word
//   --------+------------------------------+-----------------------------
//   Request | s_valid, s_ready, s_data     | op, reg_index, block_count
//   Result  | m_valid, m_ready, m_data     | granted_index, status, file_size
//
// One request per cycle sustained while m_ready holds; each request moves from
// the request register to the result register, where its result is taken.
// The free map and size update in the same edge that loads the result
// register, so the next request sees them at once.
// Reset clears the free map, the file size and both valid flags.
// A stalled result holds the request register; a new word enters as soon as
// the held one moves on.
`timescale 1ns / 1ps

module register_free_map_allocator #(
    parameter int MAX_REGS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rfma_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rfma_pkg::rsp_t m_data
);

    rfma_pkg::req_t              req_reg;
    logic                        in_valid_reg;
    rfma_pkg::rsp_t              rsp_reg;
    logic                        out_valid_reg;
    logic [MAX_REGS-1:0]         free_map_reg;
    logic [MAX_REGS-1:0]         free_map_next;
    logic [rfma_pkg::SIZE_W-1:0] size_reg;
    logic [rfma_pkg::SIZE_W-1:0] size_next;
    rfma_pkg::rsp_t              rsp_next;
    logic                        advance;

    // Handshake: the request stage moves when the result register is free or taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = rsp_reg;

    rfma_decide #(
        .MAX_REGS(MAX_REGS)
    ) u_decide (
        .req         (req_reg),
        .free_map    (free_map_reg),
        .cur_size    (size_reg),
        .rsp         (rsp_next),
        .free_map_out(free_map_next),
        .size_out    (size_next)
    );

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            free_map_reg  <= '0;
            size_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                free_map_reg  <= free_map_next;
                size_reg      <= size_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== rtl/core/rfma_decide.sv =====
// Decision logic of the register free-map allocator: one request against the
// current free map and file size gives the result word and the next state.
// Depends on rfma_pkg.
`timescale 1ns / 1ps

module rfma_decide #(
    parameter int MAX_REGS = 64
) (
    input  rfma_pkg::req_t                req,
    input  logic [MAX_REGS-1:0]           free_map,
    input  logic [rfma_pkg::SIZE_W-1:0]   cur_size,
    output rfma_pkg::rsp_t                rsp,
    output logic [MAX_REGS-1:0]           free_map_out,
    output logic [rfma_pkg::SIZE_W-1:0]   size_out
);

    logic [MAX_REGS-1:0]           size_mask;
    logic [MAX_REGS-1:0]           avail;
    logic [MAX_REGS-1:0]           used;
    logic [MAX_REGS-1:0]           idx_onehot;
    logic [MAX_REGS-1:0]           range_mask;
    logic [MAX_REGS-1:0]           low_onehot;
    logic [rfma_pkg::IDX_W-1:0]    low_idx;
    logic [rfma_pkg::SIZE_W-1:0]   start;
    logic [rfma_pkg::SIZE_W:0]     end_sum;
    logic                          idx_is_free;

    // Per-entry masks: existing entries, free and used entries, the freed
    // entry and the reserved range.
    always_comb begin
        for (int i = 0; i < MAX_REGS; i++) begin
            size_mask[i]  = rfma_pkg::SIZE_W'(i) < cur_size;
            idx_onehot[i] = rfma_pkg::IDX_W'(i) == req.reg_index;
            range_mask[i] = ((rfma_pkg::SIZE_W+1)'(i) >= {1'b0, start}) &&
                            ((rfma_pkg::SIZE_W+1)'(i) < end_sum);
        end
    end

    assign avail       = free_map & size_mask;
    assign used        = ~free_map & size_mask;
    assign idx_is_free = |(free_map & idx_onehot);
    assign end_sum     = {1'b0, start} + {1'b0, req.block_count};

    // Lowest free entry.
    always_comb begin
        low_idx    = '0;
        low_onehot = '0;
        for (int i = MAX_REGS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                low_idx    = rfma_pkg::IDX_W'(i);
                low_onehot = '0;
                low_onehot[i] = 1'b1;
            end
        end
    end

    // One past the highest entry in use, zero when none is used.
    always_comb begin
        start = '0;
        for (int i = 0; i < MAX_REGS; i++) begin
            if (used[i]) begin
                start = rfma_pkg::SIZE_W'(i + 1);
            end
        end
    end

    // Apply the request.
    always_comb begin
        rsp.granted_index = '0;
        rsp.status        = rfma_pkg::ST_DONE;
        free_map_out      = free_map;
        size_out          = cur_size;
        case (req.op)
            rfma_pkg::OP_ALLOC: begin
                if (|avail) begin
                    free_map_out      = free_map & ~low_onehot;
                    rsp.granted_index = low_idx;
                end else if (cur_size < rfma_pkg::SIZE_W'(MAX_REGS)) begin
                    rsp.granted_index = cur_size[rfma_pkg::IDX_W-1:0];
                    size_out          = cur_size + rfma_pkg::SIZE_W'(1);
                end else begin
                    rsp.status = rfma_pkg::ST_CAPACITY;
                end
            end
            rfma_pkg::OP_FREE: begin
                if (req.reg_index >= cur_size[rfma_pkg::IDX_W-1:0] && !cur_size[rfma_pkg::IDX_W]
                        || idx_is_free) begin
                    rsp.status = rfma_pkg::ST_NOT_USED;
                end else begin
                    free_map_out = free_map | idx_onehot;
                end
            end
            rfma_pkg::OP_RESERVE: begin
                if (end_sum > (rfma_pkg::SIZE_W+1)'(MAX_REGS)) begin
                    rsp.status = rfma_pkg::ST_CAPACITY;
                end else begin
                    if (req.block_count != '0) begin
                        free_map_out = free_map & ~range_mask;
                        if (end_sum > {1'b0, cur_size}) begin
                            size_out = end_sum[rfma_pkg::SIZE_W-1:0];
                        end
                    end
                    rsp.granted_index = start[rfma_pkg::IDX_W-1:0];
                end
            end
            default: begin
                // Unused opcode: no change.
            end
        endcase
        rsp.file_size = size_out;
    end

endmodule
